[hdl/ewds_pkg.sv]
// shared types and constants for the epoch window dedup set
`timescale 1ns / 1ps
package ewds_pkg;

  localparam int TableEntriesDefault = 64;
  localparam int EpochW = 64;
  localparam int TagW = 256;
  localparam int CntW = 7;

  typedef enum logic [2:0] {
    REQ_ADD      = 3'd0,
    REQ_CONTAINS = 3'd1,
    REQ_REMOVE   = 3'd2,
    REQ_COUNT    = 3'd3,
    REQ_PRUNE_BF = 3'd4,
    REQ_PRUNE_KP = 3'd5,
    REQ_CLEAR    = 3'd6,
    REQ_TOTAL    = 3'd7
  } req_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_FULL     = 3'd2,
    ST_EXISTS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  localparam logic [2:0] RegCurEpoch = 3'd0;
  localparam logic [2:0] RegMaxPer   = 3'd1;
  localparam logic [2:0] RegHistory  = 3'd2;
  localparam logic [2:0] RegFuture   = 3'd3;
  localparam logic [2:0] RegFutOff   = 3'd4;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_READ,
    FSM_SCAN,
    FSM_DECIDE,
    FSM_WRITE,
    FSM_OUT
  } fsm_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the request
    logic scan_clr;  // zero the scan counter and accumulators
    logic scan_step; // take one slot result into the accumulators
    logic decide;    // form the result word
    logic commit;    // write the table
    logic clear_all;
  } ewds_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic do_write;
    logic is_clear;
  } ewds_sts_t;

endpackage

[hdl/ewds_ctrl.sv]
// sequencer for one request: read sweep over all slots, decide, write, deliver
`timescale 1ns / 1ps
module ewds_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic               out_busy,
  input  ewds_pkg::ewds_sts_t sts,
  output ewds_pkg::ewds_cmd_t cmd,
  output logic               idle,
  output logic               res_push
);

  ewds_pkg::fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ewds_pkg::FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ewds_pkg::FSM_IDLE:   if (in_fire) state_nxt = ewds_pkg::FSM_READ;
      ewds_pkg::FSM_READ:   state_nxt = ewds_pkg::FSM_SCAN;
      ewds_pkg::FSM_SCAN:   if (sts.scan_last) state_nxt = ewds_pkg::FSM_DECIDE;
      ewds_pkg::FSM_DECIDE: state_nxt = ewds_pkg::FSM_WRITE;
      ewds_pkg::FSM_WRITE:  state_nxt = ewds_pkg::FSM_OUT;
      ewds_pkg::FSM_OUT:    if (!out_busy) state_nxt = ewds_pkg::FSM_IDLE;
      default:              state_nxt = ewds_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    idle = 1'b0;
    res_push = 1'b0;
    case (state_r)
      ewds_pkg::FSM_IDLE: begin
        idle = 1'b1;
        cmd.load = in_fire;
        cmd.scan_clr = in_fire;
      end
      ewds_pkg::FSM_READ:   ;
      ewds_pkg::FSM_SCAN:   cmd.scan_step = 1'b1;
      ewds_pkg::FSM_DECIDE: cmd.decide = 1'b1;
      ewds_pkg::FSM_WRITE: begin
        cmd.commit = sts.do_write;
        cmd.clear_all = sts.is_clear;
      end
      ewds_pkg::FSM_OUT:    res_push = !out_busy;
      default:              ;
    endcase
  end

  ap_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ewds_pkg::FSM_SCAN && sts.scan_last) |=> state_r == ewds_pkg::FSM_DECIDE)
    else $error("scan did not finish");
  ap_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> idle) else $error("load outside idle");
  ap_push_once: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> !res_push) else $error("double result push");

endmodule

[hdl/ewds_dp.sv]
// datapath: slot memory, valid bits, sweep counter and request decision
`timescale 1ns / 1ps
module ewds_dp #(
  parameter int TableEntries = ewds_pkg::TableEntriesDefault
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ewds_pkg::ewds_cmd_t       cmd,
  output ewds_pkg::ewds_sts_t       sts,
  input  logic [2:0]                req_type,
  input  logic [63:0]               req_epoch,
  input  logic [31:0]               req_keep,
  input  logic [255:0]              req_tag,
  input  logic [63:0]               cur_epoch,
  input  logic [6:0]                max_per,
  input  logic [63:0]               history,
  input  logic                      allow_fut,
  input  logic [31:0]               fut_off,
  output logic [2:0]                res_status,
  output logic                      res_found,
  output logic [6:0]                res_count
);

  localparam int IdxW = $clog2(TableEntries);
  localparam int CntAccW = IdxW + 1;

  // epoch and tag share one memory word
  logic [319:0] mem [TableEntries];
  logic [TableEntries-1:0] valid_r;

  logic [2:0]   type_r;
  logic [63:0]  epoch_r;
  logic [255:0] tag_r;
  logic [63:0]  limit_r;
  logic         keep_ok_r;

  logic [IdxW:0]   rd_idx_r;   // read address counter, one ahead
  logic [IdxW:0]   chk_idx_r;  // slot whose data is in rd_data_r
  logic [319:0]    rd_data_r;
  logic            hit_r, free_found_r;
  logic [IdxW-1:0] hit_idx_r, free_idx_r;
  logic [CntAccW-1:0] ep_cnt_r, tot_cnt_r, prune_cnt_r;
  logic [TableEntries-1:0] prune_mask_r;

  logic         do_write_r;
  logic [2:0]   status_r;
  logic         found_r;
  logic [6:0]   count_r;

  // read port: one slot a cycle
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_idx_r[IdxW-1:0]];
  end

  logic [63:0] slot_ep;
  logic slot_v, ep_eq, tag_eq, lt_lim;
  logic [IdxW-1:0] chk;
  assign chk = chk_idx_r[IdxW-1:0];
  assign slot_ep = rd_data_r[63:0];
  assign slot_v = valid_r[chk];
  assign ep_eq = slot_ep == epoch_r;
  assign tag_eq = rd_data_r[319:64] == tag_r;
  assign lt_lim = slot_ep < limit_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r <= req_type;
      epoch_r <= req_epoch;
      tag_r <= req_tag;
      keep_ok_r <= (req_type != ewds_pkg::REQ_PRUNE_KP) || (cur_epoch >= {32'd0, req_keep});
      limit_r <= (req_type == ewds_pkg::REQ_PRUNE_KP) ? cur_epoch - {32'd0, req_keep}
                                                      : req_epoch;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      rd_idx_r <= '0;
    end else begin
      rd_idx_r <= rd_idx_r + 1'b1;
    end
    chk_idx_r <= rd_idx_r;
    if (cmd.scan_clr) begin
      hit_r <= 1'b0;
      free_found_r <= 1'b0;
      hit_idx_r <= '0;
      free_idx_r <= '0;
      ep_cnt_r <= '0;
      tot_cnt_r <= '0;
      prune_cnt_r <= '0;
      prune_mask_r <= '0;
    end else if (cmd.scan_step) begin
      if (slot_v) begin
        tot_cnt_r <= tot_cnt_r + 1'b1;
        if (ep_eq) ep_cnt_r <= ep_cnt_r + 1'b1;
        if (ep_eq && tag_eq && !hit_r) begin
          hit_r <= 1'b1;
          hit_idx_r <= chk;
        end
        if (lt_lim) begin
          prune_cnt_r <= prune_cnt_r + 1'b1;
          prune_mask_r[chk] <= 1'b1;
        end
      end else if (!free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r <= chk;
      end
    end
  end

  assign sts.scan_last = chk_idx_r == CntAccW'(TableEntries - 1);
  assign sts.do_write = do_write_r;
  assign sts.is_clear = type_r == ewds_pkg::REQ_CLEAR;

  // epoch window
  logic win_ok;
  logic [63:0] back_d, fwd_d;
  assign back_d = cur_epoch - epoch_r;
  assign fwd_d = epoch_r - cur_epoch;
  always_comb begin
    win_ok = 1'b1;
    if (epoch_r < cur_epoch && back_d > history) win_ok = 1'b0;
    if (epoch_r > cur_epoch && (!allow_fut || fwd_d > {32'd0, fut_off})) win_ok = 1'b0;
  end

  function automatic logic [6:0] sat7(input logic [CntAccW-1:0] n);
    if (CntAccW > 7) begin
      return (n > CntAccW'(127)) ? 7'd127 : n[6:0];
    end
    return 7'(n);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      do_write_r <= 1'b0;
      status_r <= ewds_pkg::ST_OK;
      found_r <= 1'b0;
      count_r <= '0;
      case (ewds_pkg::req_t'(type_r))
        ewds_pkg::REQ_ADD: begin
          if (!win_ok) status_r <= ewds_pkg::ST_INVALID;
          else if (max_per != 7'd0 && {{(32-CntAccW){1'b0}}, ep_cnt_r} >= {25'd0, max_per})
            status_r <= ewds_pkg::ST_FULL;
          else if (hit_r) status_r <= ewds_pkg::ST_EXISTS;
          else if (!free_found_r) status_r <= ewds_pkg::ST_FULL;
          else do_write_r <= 1'b1;
        end
        ewds_pkg::REQ_CONTAINS, ewds_pkg::REQ_REMOVE: begin
          found_r <= hit_r;
          if (!hit_r) status_r <= ewds_pkg::ST_NOTFOUND;
          else if (type_r == ewds_pkg::REQ_REMOVE) do_write_r <= 1'b1;
        end
        ewds_pkg::REQ_COUNT: count_r <= sat7(ep_cnt_r);
        ewds_pkg::REQ_PRUNE_BF: begin
          count_r <= sat7(prune_cnt_r);
          do_write_r <= 1'b1;
        end
        ewds_pkg::REQ_PRUNE_KP: begin
          count_r <= keep_ok_r ? sat7(prune_cnt_r) : 7'd0;
          do_write_r <= keep_ok_r;
        end
        ewds_pkg::REQ_CLEAR: ;
        ewds_pkg::REQ_TOTAL: count_r <= sat7(tot_cnt_r);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && type_r == ewds_pkg::REQ_ADD) begin
      mem[free_idx_r] <= {tag_r, epoch_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.clear_all) begin
      valid_r <= '0;
    end else if (cmd.commit) begin
      case (ewds_pkg::req_t'(type_r))
        ewds_pkg::REQ_ADD:    valid_r[free_idx_r] <= 1'b1;
        ewds_pkg::REQ_REMOVE: valid_r[hit_idx_r] <= 1'b0;
        ewds_pkg::REQ_PRUNE_BF, ewds_pkg::REQ_PRUNE_KP: valid_r <= valid_r & ~prune_mask_r;
        default: ;
      endcase
    end
  end

  assign res_status = status_r;
  assign res_found = found_r;
  assign res_count = count_r;

  ap_dup_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && type_r == ewds_pkg::REQ_ADD) |-> (!hit_r && free_found_r))
    else $error("add written over duplicate or full table");
  ap_remove_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && type_r == ewds_pkg::REQ_REMOVE) |-> valid_r[hit_idx_r])
    else $error("remove of invalid slot");
  ap_add_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && type_r == ewds_pkg::REQ_ADD) |=> valid_r[$past(free_idx_r)])
    else $error("added slot not valid");

endmodule

[hdl/epoch_window_dedup_set.sv]
// top level of the epoch window dedup set: ports, config registers, output register
`timescale 1ns / 1ps
// channel   | direction | contents
// in_*      | slave     | one request transaction, tdata fields listed at the port
// out_*     | master    | one result transaction per request
// cfg_*     | apb       | five configuration registers at 8*index
// a result is valid after the one-slot-per-cycle read sweep over all entries plus the
// read, decide and write steps; a new request is not taken while one is in flight.
// reset clears the valid bits at once; the slot memory needs no clearing pass.
// a stalled out_tready holds the result; no new request is taken until it leaves.
module epoch_window_dedup_set #(
  parameter int TableEntries = ewds_pkg::TableEntriesDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // req_type[2:0], epoch[66:3], keep_epochs[98:67], tag_word0..3[354:99], zero pad
  input  logic [359:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0], found[3], count[10:4], zero pad
  output logic [15:0]  out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [5:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [63:0] cur_epoch_r, history_r;
  logic [6:0]  max_per_r;
  logic        allow_fut_r;
  logic [31:0] fut_off_r;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign reg_idx = cfg_paddr[5:3];
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2:0] == 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_epoch_r <= '0;
      max_per_r <= '0;
      history_r <= '0;
      allow_fut_r <= 1'b0;
      fut_off_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        ewds_pkg::RegCurEpoch: cur_epoch_r <= cfg_pwdata;
        ewds_pkg::RegMaxPer:   max_per_r <= cfg_pwdata[6:0];
        ewds_pkg::RegHistory:  history_r <= cfg_pwdata;
        ewds_pkg::RegFuture:   allow_fut_r <= cfg_pwdata[0];
        ewds_pkg::RegFutOff:   fut_off_r <= cfg_pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ewds_pkg::RegCurEpoch: cfg_prdata = cur_epoch_r;
      ewds_pkg::RegMaxPer:   cfg_prdata = {57'd0, max_per_r};
      ewds_pkg::RegHistory:  cfg_prdata = history_r;
      ewds_pkg::RegFuture:   cfg_prdata = {63'd0, allow_fut_r};
      ewds_pkg::RegFutOff:   cfg_prdata = {32'd0, fut_off_r};
      default:               cfg_prdata = '0;
    endcase
  end

  ewds_pkg::ewds_cmd_t cmd;
  ewds_pkg::ewds_sts_t sts;
  logic idle, res_push, in_fire;
  logic [2:0] res_status;
  logic res_found;
  logic [6:0] res_count;
  logic out_valid_r;
  logic [15:0] out_data_r;

  assign in_tready = idle && !out_valid_r;
  assign in_fire = in_tvalid && in_tready;

  ewds_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_busy(out_valid_r),
    .sts(sts), .cmd(cmd), .idle(idle), .res_push(res_push)
  );

  ewds_dp #(.TableEntries(TableEntries)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .req_type(in_tdata[2:0]), .req_epoch(in_tdata[66:3]),
    .req_keep(in_tdata[98:67]), .req_tag(in_tdata[354:99]),
    .cur_epoch(cur_epoch_r), .max_per(max_per_r), .history(history_r),
    .allow_fut(allow_fut_r), .fut_off(fut_off_r),
    .res_status(res_status), .res_found(res_found), .res_count(res_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) out_data_r <= {5'd0, res_count, res_found, res_status};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

endmodule
